[rtl/core/u16u8_pkg.sv]
package u16u8_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] CAPACITY_RESET = 16'd255;

  localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE       = 21'h10000;
  localparam logic [7:0]  BOM_FF          = 8'hFF;
  localparam logic [7:0]  BOM_FE          = 8'hFE;

  typedef logic [20:0] cp_t;
  typedef logic [2:0]  blen_t;

  typedef struct packed {
    logic        v1;
    cp_t         cp1;
    blen_t       n1;
    logic        v2;
    cp_t         cp2;
    blen_t       n2;
    logic        last;
    logic        status;
    logic [15:0] length;
  } job_t;

  function automatic blen_t utf8_len(input cp_t cp);
    blen_t n;
    if (cp <= 21'h7F) begin
      n = 3'd1;
    end else if (cp <= 21'h7FF) begin
      n = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input cp_t cp, input blen_t n, input logic [1:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (n)
      3'd1: r = cp[7:0];
      3'd2: begin
        case (i)
          2'd0:    r = {3'b110, cp[10:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (i)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (i)
          2'd0:    r = {5'b11110, cp[20:18]};
          2'd1:    r = {2'b10, cp[17:12]};
          2'd2:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/core/u16u8_in_if.sv]
interface u16u8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

[rtl/core/u16u8_out_if.sv]
interface u16u8_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        end_of_string;
  logic        status;
  logic [15:0] out_length;

  modport source (output valid, output out_byte, output byte_valid, output end_of_string,
                  output status, output out_length, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input end_of_string,
                input status, input out_length, output ready);
endinterface

[rtl/core/u16u8_front.sv]
module u16u8_front #(
  parameter int LENGTH_BITS = u16u8_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              last_byte,
  input  logic              default_be,
  input  logic [15:0]       capacity,
  input  logic              q_full,
  output logic              q_push,
  output u16u8_pkg::job_t   q_job
);
  import u16u8_pkg::*;

  localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [7:0]             held_r, held_nxt;
  logic                   half_r, half_nxt;
  logic                   first_r, first_nxt;
  logic                   active_be_r, active_be_nxt;
  logic [9:0]             pend_lo_r, pend_lo_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [LENGTH_BITS-1:0] bw_r, bw_nxt;
  logic                   stopped_r, stopped_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   accept;
  logic                   unit_here, bom_le, bom_be, bom, unit_ok, be;
  logic [15:0]            u;
  logic                   u_low, u_high, u_zero;
  logic                   p1_v, p2_v, stop_nul, np_v;
  logic [9:0]             np_lo;
  cp_t                    cp1, cp2;
  blen_t                  n1, n2;
  logic [CW-1:0]          cap_w, mask_w, cap_lim, bw_w;
  logic [LENGTH_BITS-1:0] cap_e, room, room2;
  logic                   fit1, fit2, ovf_step;

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;

  assign unit_here = !stopped_r && half_r;
  assign bom_le    = first_r && (held_r == BOM_FF) && (in_byte == BOM_FE);
  assign bom_be    = first_r && (held_r == BOM_FE) && (in_byte == BOM_FF);
  assign bom       = bom_le || bom_be;
  assign unit_ok   = unit_here && !bom;
  assign be        = first_r ? (bom_be || (!bom_le && default_be)) : active_be_r;
  assign u         = be ? {held_r, in_byte} : {in_byte, held_r};
  assign u_low     = u inside {[LOW_SURR_FIRST:LOW_SURR_LAST]};
  assign u_high    = u inside {[HIGH_SURR_FIRST:HIGH_SURR_LAST]};
  assign u_zero    = (u == 16'h0000);

  always_comb begin
    p1_v     = 1'b0;
    p2_v     = 1'b0;
    cp1      = '0;
    cp2      = '0;
    stop_nul = 1'b0;
    np_v     = pend_v_r;
    np_lo    = pend_lo_r;
    if (unit_ok) begin
      if (pend_v_r) begin
        p1_v = 1'b1;
        np_v = 1'b0;
        if (u_low) begin
          cp1 = SUPP_BASE + {1'b0, pend_lo_r, u[9:0]};
        end else begin
          cp1 = {5'b0, 6'b110110, pend_lo_r};
          if (u_zero) begin
            stop_nul = 1'b1;
          end else if (u_high) begin
            np_v  = 1'b1;
            np_lo = u[9:0];
          end else begin
            p2_v = 1'b1;
            cp2  = {5'b0, u};
          end
        end
      end else begin
        if (u_zero) begin
          stop_nul = 1'b1;
        end else if (u_high) begin
          np_v  = 1'b1;
          np_lo = u[9:0];
        end else begin
          p1_v = 1'b1;
          cp1  = {5'b0, u};
        end
      end
    end
    if (last_byte && np_v && !stop_nul && !stopped_r) begin
      np_v = 1'b0;
      if (p1_v) begin
        p2_v = 1'b1;
        cp2  = {5'b0, 6'b110110, np_lo};
      end else begin
        p1_v = 1'b1;
        cp1  = {5'b0, 6'b110110, np_lo};
      end
    end
  end

  assign n1      = utf8_len(cp1);
  assign n2      = utf8_len(cp2);
  assign cap_w   = CW'(capacity);
  assign mask_w  = CW'({LENGTH_BITS{1'b1}});
  assign cap_lim = (cap_w > mask_w) ? mask_w : cap_w;
  assign cap_e   = cap_lim[LENGTH_BITS-1:0];
  assign room    = (cap_e > bw_r) ? (cap_e - bw_r) : '0;
  assign fit1    = p1_v && (LENGTH_BITS'(n1) <= room);
  assign room2   = room - LENGTH_BITS'(n1);
  assign fit2    = p2_v && fit1 && (LENGTH_BITS'(n2) <= room2);
  assign ovf_step = (p1_v && !fit1) || (p2_v && fit1 && !fit2);

  always_comb begin
    held_nxt      = held_r;
    half_nxt      = half_r;
    first_nxt     = first_r;
    active_be_nxt = active_be_r;
    pend_lo_nxt   = pend_lo_r;
    pend_v_nxt    = pend_v_r;
    bw_nxt        = bw_r;
    stopped_nxt   = stopped_r;
    ovf_nxt       = ovf_r;
    if (!stopped_r) begin
      if (!half_r) begin
        held_nxt = in_byte;
        half_nxt = 1'b1;
      end else begin
        half_nxt      = 1'b0;
        first_nxt     = 1'b0;
        active_be_nxt = be;
      end
      pend_v_nxt  = np_v;
      pend_lo_nxt = np_lo;
      bw_nxt      = bw_r + (fit1 ? LENGTH_BITS'(n1) : '0) + (fit2 ? LENGTH_BITS'(n2) : '0);
      stopped_nxt = ovf_step || stop_nul;
      ovf_nxt     = ovf_step;
    end
  end

  assign bw_w = CW'(bw_nxt);

  always_comb begin
    q_job.v1     = fit1;
    q_job.cp1    = cp1;
    q_job.n1     = n1;
    q_job.v2     = fit2;
    q_job.cp2    = cp2;
    q_job.n2     = n2;
    q_job.last   = last_byte;
    q_job.status = ovf_nxt;
    q_job.length = bw_w[15:0];
  end

  assign q_push = accept && (fit1 || fit2 || last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      half_r      <= 1'b0;
      first_r     <= 1'b1;
      active_be_r <= 1'b0;
      pend_lo_r   <= '0;
      pend_v_r    <= 1'b0;
      bw_r        <= '0;
      stopped_r   <= 1'b0;
      ovf_r       <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        held_r      <= '0;
        half_r      <= 1'b0;
        first_r     <= 1'b1;
        active_be_r <= default_be;
        pend_lo_r   <= '0;
        pend_v_r    <= 1'b0;
        bw_r        <= '0;
        stopped_r   <= 1'b0;
        ovf_r       <= 1'b0;
      end else begin
        held_r      <= held_nxt;
        half_r      <= half_nxt;
        first_r     <= first_nxt;
        active_be_r <= active_be_nxt;
        pend_lo_r   <= pend_lo_nxt;
        pend_v_r    <= pend_v_nxt;
        bw_r        <= bw_nxt;
        stopped_r   <= stopped_nxt;
        ovf_r       <= ovf_nxt;
      end
    end
  end

endmodule

[rtl/core/u16u8_fifo.sv]
module u16u8_fifo #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output u16u8_pkg::job_t head
);
  import u16u8_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CNTW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  assign wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/core/u16u8_back.sv]
module u16u8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  u16u8_pkg::job_t head,
  output logic            pop,
  u16u8_out_if.source     out_ch
);
  import u16u8_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r;
  logic        bv_r, eos_r, st_r;
  logic [15:0] len_r;

  blen_t       n1e, n2e, count, last_idx;
  logic        can_load, emit, final_beat;
  logic [7:0]  sel_byte;
  logic [2:0]  idx2;

  assign n1e        = head.v1 ? head.n1 : '0;
  assign n2e        = head.v2 ? head.n2 : '0;
  assign count      = n1e + n2e;
  assign last_idx   = (count == '0) ? '0 : count - 1'b1;
  assign can_load   = !out_valid_r || out_ch.ready;
  assign emit       = head_valid && can_load;
  assign final_beat = (idx_r == last_idx);
  assign pop        = emit && final_beat;
  assign idx2       = idx_r - n1e;

  always_comb begin
    if (idx_r < n1e) begin
      sel_byte = utf8_byte(head.cp1, head.n1, idx_r[1:0]);
    end else begin
      sel_byte = utf8_byte(head.cp2, head.n2, idx2[1:0]);
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = final_beat ? '0 : idx_r + 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= (count == '0) ? 8'h00 : sel_byte;
      bv_r   <= (count != '0);
      eos_r  <= head.last && final_beat;
      st_r   <= head.last && final_beat && head.status;
      len_r  <= (head.last && final_beat) ? head.length : 16'h0000;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = byte_r;
  assign out_ch.byte_valid    = bv_r;
  assign out_ch.end_of_string = eos_r;
  assign out_ch.status        = st_r;
  assign out_ch.out_length    = len_r;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n) idx_r <= 3'd5)
    else $error("Byte index ran past the largest beat count.");
  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n) pop |=> idx_r == 3'd0)
    else $error("Byte index did not restart after a job was retired.");
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && !bv_r |-> eos_r)
    else $error("A beat without a byte was not the end of a string.");
  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
      !head_valid |-> !pop)
    else $error("A job was retired from an empty queue.");
`endif

endmodule

[rtl/core/utf16_to_utf8_transcoder.sv]
// UTF-16 to UTF-8 transcoder.
// The in_ch channel takes one source byte per beat, with last_byte set on the
// final byte of a string. The out_ch channel gives one UTF-8 byte per beat; the
// final beat of a string carries end_of_string, the overflow status and the
// produced length, and has byte_valid low when that byte produced nothing.
// A byte order mark in the first two bytes selects the byte order, otherwise
// the byte order register is used. The APB port holds the byte order register
// at address 0 and the output capacity at address 4.
// The front section pairs bytes into code units and sizes each code point
// combinationally, so one source byte is taken every cycle while the job queue
// has room. The back section emits one output byte per cycle while the receiver
// takes them, so the sustained rate is set by the output side; a source byte
// causes up to six output bytes. The first output byte of an item passes
// through the job queue and then the output register.
// A stalled receiver holds the output register; the queue then fills and
// in_ch.ready drops. Synchronous reset clears the queue, the string state and
// the registers (little endian, capacity 255).
module utf16_to_utf8_transcoder #(
  parameter int LENGTH_BITS = u16u8_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  u16u8_in_if.sink     in_ch,
  u16u8_out_if.source  out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import u16u8_pkg::*;

  localparam logic REG_BYTE_ORDER = 1'b0;
  localparam logic REG_CAPACITY   = 1'b1;

  logic        dbe_r;
  logic [15:0] cap_r;
  logic        cfg_wr;

  logic        q_full, q_push, q_pop, q_not_empty;
  job_t        q_job, q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbe_r <= 1'b0;
      cap_r <= CAPACITY_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BYTE_ORDER: dbe_r <= pwdata[0];
        REG_CAPACITY:   cap_r <= pwdata[15:0];
        default:        dbe_r <= dbe_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BYTE_ORDER: prdata = {31'b0, dbe_r};
      REG_CAPACITY:   prdata = {16'b0, cap_r};
      default:        prdata = '0;
    endcase
  end

  u16u8_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.in_byte),
    .last_byte  (in_ch.last_byte),
    .default_be (dbe_r),
    .capacity   (cap_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  u16u8_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_not_empty),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

[test/transcode_checker.sv]
`timescale 1ns / 1ps

module transcode_checker #(
  parameter logic [2:0] BYTE_ORDER_ADDR = 3'd0,
  parameter logic [2:0] CAPACITY_ADDR = 3'd4
) (
  input  logic        clk,
  input  logic        rst_n,
  u16u8_in_if         in_mon,
  u16u8_out_if        out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          due_count,
  output int          beats_seen,
  output int          strings_seen,
  output int          overflows_seen
);
  import u16u8_pkg::*;

  typedef struct packed {
    logic [7:0]  data;
    logic        byte_valid;
    logic        end_of_string;
    logic        status;
    logic [15:0] length;
  } utf8_beat_t;

  logic        cfg_big;
  logic [15:0] cfg_cap;

  logic [7:0]  held_q;
  logic        half_q;
  logic        first_q;
  logic        big_q;
  logic [15:0] high_q;
  logic        high_v;
  logic [15:0] written_q;
  logic        stopped_q;
  logic        ovf_q;

  logic [7:0]  step_bytes[$];
  utf8_beat_t  utf8_due[$];

  function automatic void restart_string();
    held_q = 8'h00;
    half_q = 1'b0;
    first_q = 1'b1;
    big_q = cfg_big;
    high_q = 16'h0000;
    high_v = 1'b0;
    written_q = 16'h0000;
    stopped_q = 1'b0;
    ovf_q = 1'b0;
  endfunction

  // A code point is written whole or not at all; a miss ends the string's output.
  function automatic void emit_cp(input logic [20:0] cp);
    int unsigned room;
    int unsigned n;
    room = (cfg_cap > written_q) ? int'(cfg_cap - written_q) : 0;
    if (cp <= 21'h7F) begin
      n = 1;
    end else if (cp <= 21'h7FF) begin
      n = 2;
    end else if (cp <= 21'hFFFF) begin
      n = 3;
    end else begin
      n = 4;
    end
    if (n > room || step_bytes.size() + n > 8) begin
      stopped_q = 1'b1;
      ovf_q = 1'b1;
      return;
    end
    case (n)
      1: step_bytes.push_back(cp[7:0]);
      2: begin
        step_bytes.push_back({3'b110, cp[10:6]});
        step_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        step_bytes.push_back({4'b1110, cp[15:12]});
        step_bytes.push_back({2'b10, cp[11:6]});
        step_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        step_bytes.push_back({5'b11110, cp[20:18]});
        step_bytes.push_back({2'b10, cp[17:12]});
        step_bytes.push_back({2'b10, cp[11:6]});
        step_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
    written_q = written_q + 16'(n);
  endfunction

  function automatic void take_unit(input logic [15:0] u);
    logic [15:0] hi_off;
    logic [15:0] lo_off;
    if (high_v) begin
      high_v = 1'b0;
      if (u >= LOW_SURR_FIRST && u <= LOW_SURR_LAST) begin
        hi_off = high_q - HIGH_SURR_FIRST;
        lo_off = u - LOW_SURR_FIRST;
        emit_cp(SUPP_BASE + {1'b0, hi_off[9:0], lo_off[9:0]});
        high_q = 16'h0000;
        return;
      end
      emit_cp({5'd0, high_q});
      high_q = 16'h0000;
      if (stopped_q) return;
    end
    if (u == 16'h0000) begin
      stopped_q = 1'b1;
      return;
    end
    if (u >= HIGH_SURR_FIRST && u <= HIGH_SURR_LAST) begin
      high_q = u;
      high_v = 1'b1;
      return;
    end
    emit_cp({5'd0, u});
  endfunction

  function automatic void transcode_byte(input logic [7:0] b, input logic last);
    logic       bom;
    utf8_beat_t item;
    int         k;
    step_bytes.delete();
    bom = 1'b0;
    if (!stopped_q) begin
      if (!half_q) begin
        held_q = b;
        half_q = 1'b1;
      end else begin
        half_q = 1'b0;
        if (first_q) begin
          first_q = 1'b0;
          big_q = cfg_big;
          if (held_q == BOM_FF && b == BOM_FE) begin
            big_q = 1'b0;
            bom = 1'b1;
          end else if (held_q == BOM_FE && b == BOM_FF) begin
            big_q = 1'b1;
            bom = 1'b1;
          end
        end
        if (!bom) begin
          take_unit(big_q ? {held_q, b} : {b, held_q});
        end
      end
      if (last && !stopped_q && high_v) begin
        high_v = 1'b0;
        emit_cp({5'd0, high_q});
        high_q = 16'h0000;
      end
    end
    if (last && step_bytes.size() == 0) begin
      item = '{data: 8'h00, byte_valid: 1'b0, end_of_string: 1'b1,
               status: ovf_q, length: written_q};
      utf8_due.push_back(item);
    end
    for (k = 0; k < step_bytes.size(); k++) begin
      item = '{data: step_bytes[k], byte_valid: 1'b1, end_of_string: 1'b0,
               status: 1'b0, length: 16'h0000};
      if (last && k == step_bytes.size() - 1) begin
        item.end_of_string = 1'b1;
        item.status = ovf_q;
        item.length = written_q;
      end
      utf8_due.push_back(item);
    end
    if (last) restart_string();
  endfunction

  always @(posedge clk) begin
    utf8_beat_t want;
    if (!rst_n) begin
      errors = 0;
      beats_seen = 0;
      strings_seen = 0;
      overflows_seen = 0;
      cfg_big = 1'b0;
      cfg_cap = CAPACITY_RESET;
      restart_string();
      utf8_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == BYTE_ORDER_ADDR) begin
          cfg_big = pwdata[0];
        end else if (paddr == CAPACITY_ADDR) begin
          cfg_cap = pwdata[15:0];
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        transcode_byte(in_mon.in_byte, in_mon.last_byte);
      end
      if (out_mon.valid && out_mon.ready) begin
        beats_seen++;
        if (utf8_due.size() == 0) begin
          $error("unexpected output beat: out_byte %0h, end_of_string %0b",
                 out_mon.out_byte, out_mon.end_of_string);
          errors++;
        end else begin
          want = utf8_due.pop_front();
          if (out_mon.out_byte !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_mon.out_byte);
            errors++;
          end
          if (out_mon.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_mon.byte_valid);
            errors++;
          end
          if (out_mon.end_of_string !== want.end_of_string) begin
            $error("end_of_string: expected %0b, got %0b", want.end_of_string,
                   out_mon.end_of_string);
            errors++;
          end
          if (out_mon.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, out_mon.status);
            errors++;
          end
          if (out_mon.out_length !== want.length) begin
            $error("out_length: expected %0d, got %0d", want.length, out_mon.out_length);
            errors++;
          end
          if (want.end_of_string) begin
            strings_seen++;
            if (want.status) overflows_seen++;
          end
        end
      end
    end
    due_count = utf8_due.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import u16u8_pkg::*;

  localparam logic [2:0] ADDR_BYTE_ORDER = 3'd0;
  localparam logic [2:0] ADDR_CAPACITY = 3'd4;
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH_DEF + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 400;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  u16u8_in_if  in_if ();
  u16u8_out_if out_if ();

  int errors;
  int due_count;
  int beats_seen;
  int strings_seen;
  int overflows_seen;

  int src_idle = 0;
  int snk_stall = 0;
  int rx_hold = 0;
  int bytes_sent = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  logic [7:0] src[$];

  utf16_to_utf8_transcoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  transcode_checker #(
    .BYTE_ORDER_ADDR (ADDR_BYTE_ORDER),
    .CAPACITY_ADDR   (ADDR_CAPACITY)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .errors         (errors),
    .due_count      (due_count),
    .beats_seen     (beats_seen),
    .strings_seen   (strings_seen),
    .overflows_seen (overflows_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d beats still due.", due_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver either honors a requested hold-off or stalls at random.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_stall);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_if.last_byte <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input logic close);
    foreach (src[i]) begin
      send_byte(src[i], close && (i == src.size() - 1));
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
  endtask

  task automatic push_unit(input logic [15:0] u, input logic big);
    if (big) begin
      src.push_back(u[15:8]);
      src.push_back(u[7:0]);
    end else begin
      src.push_back(u[7:0]);
      src.push_back(u[15:8]);
    end
  endtask

  task automatic build_string(input logic big_default);
    logic        big;
    logic [15:0] u;
    int          kind;
    int          n_units;
    src.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) src.push_back(8'($urandom_range(255)));
      return;
    end
    big = big_default;
    case ($urandom_range(2))
      1: begin
        src.push_back(BOM_FF);
        src.push_back(BOM_FE);
        big = 1'b0;
      end
      2: begin
        src.push_back(BOM_FE);
        src.push_back(BOM_FF);
        big = 1'b1;
      end
      default: ;
    endcase
    n_units = $urandom_range(1, 5);
    repeat (n_units) begin
      kind = $urandom_range(19);
      if (kind < 5) begin
        u = 16'($urandom_range(1, 16'h7F));
      end else if (kind < 9) begin
        u = 16'($urandom_range(16'h80, 16'h7FF));
      end else if (kind < 13) begin
        if ($urandom_range(1)) u = 16'($urandom_range(16'h800, HIGH_SURR_FIRST - 1));
        else u = 16'($urandom_range(LOW_SURR_LAST + 1, 16'hFFFF));
      end else if (kind < 17) begin
        push_unit(16'($urandom_range(HIGH_SURR_FIRST, HIGH_SURR_LAST)), big);
        u = 16'($urandom_range(LOW_SURR_FIRST, LOW_SURR_LAST));
      end else if (kind < 18) begin
        u = 16'($urandom_range(HIGH_SURR_FIRST, HIGH_SURR_LAST));
      end else if (kind < 19) begin
        u = 16'($urandom_range(LOW_SURR_FIRST, LOW_SURR_LAST));
      end else begin
        u = 16'h0000;
      end
      push_unit(u, big);
    end
    if ($urandom_range(4) == 0) src.push_back(8'($urandom_range(255)));
  endtask

  task automatic run_phase(input logic big, input logic [15:0] cap, input int idle_pct,
                           input int stall_pct, input int budget, input int hold);
    int start;
    settle();
    write_reg(ADDR_BYTE_ORDER, {31'd0, big});
    write_reg(ADDR_CAPACITY, {16'd0, cap});
    src_idle = idle_pct;
    snk_stall = stall_pct;
    rx_hold = hold;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_string(big);
      send_string(1'b1);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.last_byte = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src = '{8'hFF, 8'hFE, 8'h7F, 8'h00, 8'h80, 8'h00, 8'h3D, 8'hD8, 8'h00, 8'hDE,
            8'hFF, 8'hFF};
    send_string(1'b1);
    src = '{8'hFE, 8'hFF, 8'hD8, 8'h00, 8'h00, 8'h41, 8'hDF, 8'hFF, 8'h7E};
    send_string(1'b1);

    // The byte order register is changed after the first byte of a string.
    src = '{8'h00};
    send_string(1'b0);
    settle();
    write_reg(ADDR_BYTE_ORDER, 32'd1);
    src = '{8'h41, 8'hDB, 8'hFF};
    send_string(1'b1);

    // The capacity drops below what the open string has already written.
    src = '{8'h00, 8'h41, 8'h00, 8'h42};
    send_string(1'b0);
    settle();
    write_reg(ADDR_CAPACITY, 32'd1);
    src = '{8'h00, 8'h43};
    send_string(1'b1);
    src = '{8'h00, 8'h00, 8'h55};
    send_string(1'b1);
    src = '{8'hFF};
    send_string(1'b1);

    run_phase(1'b1, 16'hFFFF, 57, 0, 22, 0);
    run_phase(1'b0, 16'd5, 0, 57, 22, LONG_HOLD);
    run_phase(1'b1, 16'd0, 10, 10, 8, 0);
    run_phase(1'b0, 16'd300, 0, 0, 18, 0);

    settle();
    $display("Sent %0d source bytes with %0d register writes; checked %0d output beats.",
             bytes_sent, reg_writes, beats_seen);
    $display("Closed %0d strings, %0d of them on a capacity overflow.",
             strings_seen, overflows_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[utf16_to_utf8_transcoder.f]
rtl/core/u16u8_pkg.sv
rtl/core/u16u8_in_if.sv
rtl/core/u16u8_out_if.sv
rtl/core/u16u8_front.sv
rtl/core/u16u8_fifo.sv
rtl/core/u16u8_back.sv
rtl/core/utf16_to_utf8_transcoder.sv
test/transcode_checker.sv
test/tb.sv
